[sv/rhc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhc_pkg
// Shared constants for the RGB to hue / HSV / HSL converter.
// ----------------------------------------------------------------------------
package rhc_pkg;

	// default component width of one color channel
	localparam int unsigned COMPONENT_BITS_DEF = 8;

	// fraction bits of hue and of both saturations
	localparam int unsigned FRAC_BITS = 16;

	// one division step per pipeline stage
	localparam int unsigned DIV_STAGES = FRAC_BITS;

endpackage

[sv/rhc_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhc_pixel_if / rhc_result_if
// Valid/ready channels: one RGB pixel in, one hue/HSV/HSL word out.
// ----------------------------------------------------------------------------
interface rhc_pixel_if
	import rhc_pkg::*;
	#(parameter int unsigned COMPONENT_BITS = COMPONENT_BITS_DEF);

	logic                      valid;
	logic                      ready;
	logic [COMPONENT_BITS-1:0] red;
	logic [COMPONENT_BITS-1:0] green;
	logic [COMPONENT_BITS-1:0] blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink   (input valid, input red, input green, input blue, output ready);

endinterface

interface rhc_result_if
	import rhc_pkg::*;
	#(parameter int unsigned COMPONENT_BITS = COMPONENT_BITS_DEF);

	logic                      valid;
	logic                      ready;
	logic [FRAC_BITS-1:0]      hue;
	logic [FRAC_BITS-1:0]      hsv_saturation;
	logic [COMPONENT_BITS-1:0] hsv_value;
	logic [FRAC_BITS-1:0]      hsl_saturation;
	logic [COMPONENT_BITS:0]   lightness_doubled;

	modport source (output valid, output hue, output hsv_saturation, output hsv_value,
		output hsl_saturation, output lightness_doubled, input ready);
	modport sink   (input valid, input hue, input hsv_saturation, input hsv_value,
		input hsl_saturation, input lightness_doubled, output ready);

endinterface

[sv/rgb_to_hsv_hsl_convert.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_hsv_hsl_convert
// Pipelined RGB to hue, HSV and HSL conversion, one pixel per clock when not stalled.
// ----------------------------------------------------------------------------
// Usage:
//   pixel  : sink channel, one word per RGB pixel (red, green, blue).
//   result : source channel, one word per pixel with hue, HSV saturation,
//            value, HSL saturation and doubled lightness.
//   The block keeps no state between pixels; every word is converted on its
//   own and results leave in the order pixels arrived.
// Pipeline: the range stage registers at the accepting edge, then 16
//   restoring-division stages follow, each of which resolves one quotient
//   bit of all three dividers; the last of them drives result.valid.
// Throughput: one pixel per clock while result.ready stays high.
// Stall: each stage holds its word while the stage after it is full and not
//   advancing; empty stages still fill, so bubbles collapse and pixel.ready
//   stays high until the whole pipe is full behind a stalled receiver.
// Reset: arst_n clears all valid bits; no output word is pending after it.
// ----------------------------------------------------------------------------
module rgb_to_hsv_hsl_convert
	import rhc_pkg::*;
	#(parameter int unsigned COMPONENT_BITS = COMPONENT_BITS_DEF)
	(
	input  logic clk,
	input  logic arst_n,
	rhc_pixel_if.sink    pixel,
	rhc_result_if.source result
	);

	localparam int unsigned CB = COMPONENT_BITS;
	localparam int unsigned HW = CB + 3;     // holds 6 * d
	localparam int unsigned QW = FRAC_BITS;

	typedef struct packed {
		logic [CB-1:0] mx;
		logic [CB:0]   sum;
		logic [HW-1:0] hue_rem;
		logic [HW-1:0] hue_den;
		logic [QW-1:0] hue_q;
		logic [CB-1:0] hsv_rem;
		logic [CB-1:0] hsv_den;
		logic [QW-1:0] hsv_lo;
		logic [QW-1:0] hsv_q;
		logic [CB-1:0] hsl_rem;
		logic [CB-1:0] hsl_den;
		logic [QW-1:0] hsl_lo;
		logic [QW-1:0] hsl_q;
	} stage_t;

	// one restoring-division step on all three quotients
	function automatic stage_t div_step(stage_t a);
		stage_t      b;
		logic [HW:0] th;
		logic [CB:0] tv;
		logic [CB:0] tl;
		b  = a;
		th = {a.hue_rem, 1'b0};
		if (th >= {1'b0, a.hue_den}) begin
			b.hue_rem = HW'(th - {1'b0, a.hue_den});
			b.hue_q   = {a.hue_q[QW-2:0], 1'b1};
		end else begin
			b.hue_rem = th[HW-1:0];
			b.hue_q   = {a.hue_q[QW-2:0], 1'b0};
		end
		tv = {a.hsv_rem, a.hsv_lo[QW-1]};
		b.hsv_lo = {a.hsv_lo[QW-2:0], 1'b0};
		if (tv >= {1'b0, a.hsv_den}) begin
			b.hsv_rem = CB'(tv - {1'b0, a.hsv_den});
			b.hsv_q   = {a.hsv_q[QW-2:0], 1'b1};
		end else begin
			b.hsv_rem = tv[CB-1:0];
			b.hsv_q   = {a.hsv_q[QW-2:0], 1'b0};
		end
		tl = {a.hsl_rem, a.hsl_lo[QW-1]};
		b.hsl_lo = {a.hsl_lo[QW-2:0], 1'b0};
		if (tl >= {1'b0, a.hsl_den}) begin
			b.hsl_rem = CB'(tl - {1'b0, a.hsl_den});
			b.hsl_q   = {a.hsl_q[QW-2:0], 1'b1};
		end else begin
			b.hsl_rem = tl[CB-1:0];
			b.hsl_q   = {a.hsl_q[QW-2:0], 1'b0};
		end
		return b;
	endfunction

	// ------------------------------------------------------------------
	// Range stage: max, min, sextant numerator and divisors.
	// ------------------------------------------------------------------
	logic [CB-1:0] r, g, b, mx, mn, d;
	logic [CB:0]   sum, fs2_minus;
	logic [HW-1:0] d6, num;
	logic [CB-1:0] hsl_den;
	stage_t        s1_next;

	assign r = pixel.red;
	assign g = pixel.green;
	assign b = pixel.blue;

	always_comb begin
		mx = r;
		mn = r;
		if (g > mx) mx = g;
		if (b > mx) mx = b;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
		d   = mx - mn;
		sum = {1'b0, mx} + {1'b0, mn};
		d6  = HW'({d, 2'b00}) + HW'({d, 1'b0});

		// red wins ties, then green; red sextant wraps by adding a full turn
		if (r == mx) begin
			if (g >= b) num = HW'(g) - HW'(b);
			else        num = d6 - (HW'(b) - HW'(g));
		end else if (g == mx) begin
			num = HW'({d, 1'b0}) + HW'(b) - HW'(r);
		end else begin
			num = HW'({d, 2'b00}) + HW'(r) - HW'(g);
		end

		fs2_minus = {{CB{1'b1}}, 1'b0} - sum;
		if (sum <= {1'b0, {CB{1'b1}}}) hsl_den = sum[CB-1:0];
		else                           hsl_den = fs2_minus[CB-1:0];

		s1_next     = '0;
		s1_next.mx  = mx;
		s1_next.sum = sum;
		if (d == '0) begin
			// grey: remainders zero over unit divisors give zero quotients
			s1_next.hue_den = HW'(1);
			s1_next.hsv_den = CB'(1);
			s1_next.hsl_den = CB'(1);
		end else begin
			// d * 65535 split as high part d - 1 and low 16 bits -d
			s1_next.hue_rem = num;
			s1_next.hue_den = d6;
			s1_next.hsv_rem = d - CB'(1);
			s1_next.hsv_den = mx;
			s1_next.hsv_lo  = QW'(0) - QW'(d);
			s1_next.hsl_rem = d - CB'(1);
			s1_next.hsl_den = hsl_den;
			s1_next.hsl_lo  = QW'(0) - QW'(d);
		end
	end

	// ------------------------------------------------------------------
	// Pipeline: stage 0 is the range stage, 1..DIV_STAGES divide.
	// ------------------------------------------------------------------
	logic   [DIV_STAGES:0]   v_s;
	logic   [DIV_STAGES+1:0] adv;
	stage_t                  pipe_s [DIV_STAGES+1];

	// advance a stage when it is empty or its successor advances
	always_comb begin
		adv[DIV_STAGES+1] = result.ready;
		for (int k = DIV_STAGES; k >= 0; k--) begin
			adv[k] = !v_s[k] || adv[k+1];
		end
	end

	assign pixel.ready = adv[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (adv[0]) begin
			v_s[0] <= pixel.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[0] && pixel.valid) begin
			pipe_s[0] <= s1_next;
		end
	end

	for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_div
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (adv[k]) begin
				v_s[k] <= v_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv[k] && v_s[k-1]) begin
				pipe_s[k] <= div_step(pipe_s[k-1]);
			end
		end
	end

	// last stage is the output register
	assign result.valid             = v_s[DIV_STAGES];
	assign result.hue               = pipe_s[DIV_STAGES].hue_q;
	assign result.hsv_saturation    = pipe_s[DIV_STAGES].hsv_q;
	assign result.hsv_value         = pipe_s[DIV_STAGES].mx;
	assign result.hsl_saturation    = pipe_s[DIV_STAGES].hsl_q;
	assign result.lightness_doubled = pipe_s[DIV_STAGES].sum;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_ready_follows: assert property (@(posedge clk) disable iff (!arst_n)
		result.ready |-> pixel.ready)
		else $error("pixel.ready low while the receiver takes words");

	a_rem_first: assert property (@(posedge clk) disable iff (!arst_n)
		v_s[0] |-> (pipe_s[0].hue_rem < pipe_s[0].hue_den) &&
			(pipe_s[0].hsv_rem < pipe_s[0].hsv_den) &&
			(pipe_s[0].hsl_rem < pipe_s[0].hsl_den))
		else $error("initial remainder not below divisor");

	a_rem_last: assert property (@(posedge clk) disable iff (!arst_n)
		v_s[DIV_STAGES] |->
			(pipe_s[DIV_STAGES].hue_rem < pipe_s[DIV_STAGES].hue_den) &&
			(pipe_s[DIV_STAGES].hsv_rem < pipe_s[DIV_STAGES].hsv_den) &&
			(pipe_s[DIV_STAGES].hsl_rem < pipe_s[DIV_STAGES].hsl_den))
		else $error("final remainder not below divisor");

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for rgb_to_hsv_hsl_convert: a queue-fed driver offers
// pixels with random gaps, a monitor with random back-pressure checks every
// result word against an integer hue/HSV/HSL predictor, in arrival order.
// ----------------------------------------------------------------------------
module tb;
	import rhc_pkg::*;

	localparam int unsigned CB = COMPONENT_BITS_DEF;
	localparam int unsigned FS = (1 << CB) - 1;

	typedef struct packed {
		logic [CB-1:0] red;
		logic [CB-1:0] green;
		logic [CB-1:0] blue;
	} pixel_t;

	typedef struct packed {
		logic [FRAC_BITS-1:0] hue;
		logic [FRAC_BITS-1:0] hsv_sat;
		logic [CB-1:0]        value;
		logic [FRAC_BITS-1:0] hsl_sat;
		logic [CB:0]          light2;
	} color_t;

	logic clk;
	logic arst_n;

	rhc_pixel_if  #(.COMPONENT_BITS(CB)) pixel_ch ();
	rhc_result_if #(.COMPONENT_BITS(CB)) result_ch ();

	rgb_to_hsv_hsl_convert #(.COMPONENT_BITS(CB)) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pixel  (pixel_ch.sink),
		.result (result_ch.source)
	);

	pixel_t pending_pixels[$];
	color_t expected_colors[$];
	int     mismatches;
	int     pixels_sent;
	int     colors_seen;
	bit     stimulus_done;
	bit     hold_off;
	bit     pixel_taken;

	// Convert one pixel with exact integer math, truncating each quotient.
	function automatic color_t convert_pixel(pixel_t p);
		color_t c;
		longint unsigned r, g, b, mx, mn, d, sum, denom, num;
		r = p.red;
		g = p.green;
		b = p.blue;
		mx = r;
		mn = r;
		if (g > mx) mx = g;
		if (b > mx) mx = b;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
		d = mx - mn;
		sum = mx + mn;
		c = '0;
		if (d != 0) begin
			// red wins ties, then green
			if (r == mx) begin
				num = (g >= b) ? g - b : 6 * d - (b - g);
			end else if (g == mx) begin
				num = 2 * d + b - r;
			end else begin
				num = 4 * d + r - g;
			end
			c.hue = FRAC_BITS'((num * 65536) / (6 * d));
			denom = (sum <= FS) ? sum : 2 * FS - sum;
			c.hsl_sat = FRAC_BITS'((d * 65535) / denom);
		end
		if (mx != 0) c.hsv_sat = FRAC_BITS'((d * 65535) / mx);
		c.value = CB'(mx);
		c.light2 = (CB+1)'(sum);
		return c;
	endfunction

	task automatic report_mismatch(string field, longint unsigned got, longint unsigned want);
		$display("[%0t] word %0d: %s got %0d, want %0d", $time, colors_seen, field, got, want);
		mismatches++;
	endtask

	task automatic queue_pixel(int r, int g, int b);
		pixel_t p;
		p.red = CB'(r);
		p.green = CB'(g);
		p.blue = CB'(b);
		pending_pixels.push_back(p);
	endtask

	// Mostly short gaps, now and then a long one.
	function automatic int gap_len();
		int sel;
		sel = $urandom_range(99);
		if (sel < 55) return 0;
		if (sel < 92) return $urandom_range(3, 1);
		return $urandom_range(30, 8);
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// Directed pixels: black, white, greys, primaries, ties, wrap of red sextant.
	initial begin
		int n, kind, base;
		queue_pixel(0, 0, 0);
		queue_pixel(FS, FS, FS);
		queue_pixel(128, 128, 128);
		queue_pixel(FS, 0, 0);
		queue_pixel(0, FS, 0);
		queue_pixel(0, 0, FS);
		queue_pixel(FS, FS, 0);
		queue_pixel(0, FS, FS);
		queue_pixel(FS, 0, FS);
		queue_pixel(200, 200, 10);
		queue_pixel(10, 200, 200);
		queue_pixel(200, 10, 200);
		queue_pixel(FS, 0, 1);
		queue_pixel(FS, 1, 0);
		queue_pixel(1, 0, 0);
		queue_pixel(FS, FS, FS - 1);
		queue_pixel(0, 1, FS);
		queue_pixel(FS, 254, 0);
		queue_pixel(127, 128, 129);
		queue_pixel(170, 85, 0);
		// Random pixels: mix of full range, near-grey and dim/bright extremes.
		for (n = 0; n < 700; n++) begin
			kind = $urandom_range(9);
			if (kind < 6) begin
				queue_pixel($urandom_range(FS), $urandom_range(FS), $urandom_range(FS));
			end else if (kind < 8) begin
				base = $urandom_range(FS);
				queue_pixel(base, (base + $urandom_range(2)) % (FS + 1),
					(base + FS - $urandom_range(1)) % (FS + 1));
			end else if (kind == 8) begin
				queue_pixel($urandom_range(3), $urandom_range(3), $urandom_range(3));
			end else begin
				queue_pixel(FS - $urandom_range(3), FS - $urandom_range(3),
					$urandom_range(FS));
			end
		end
	end

	// Driver: offer the head of the queue, advance on acceptance.
	initial begin
		pixel_ch.valid = 1'b0;
		pixel_ch.red   = '0;
		pixel_ch.green = '0;
		pixel_ch.blue  = '0;
	end

	int drive_gap;
	always @(negedge clk) begin
		if (arst_n) begin
			if (pixel_taken) begin
				// word was taken at the last rising edge
				pending_pixels.pop_front();
				pixels_sent <= pixels_sent + 1;
				drive_gap = gap_len();
			end
			if (!pixel_ch.valid || pixel_taken) begin
				if (drive_gap > 0) begin
					drive_gap--;
					pixel_ch.valid <= 1'b0;
				end else if (pending_pixels.size() > 0) begin
					pixel_ch.valid <= 1'b1;
					pixel_ch.red   <= pending_pixels[0].red;
					pixel_ch.green <= pending_pixels[0].green;
					pixel_ch.blue  <= pending_pixels[0].blue;
				end else begin
					pixel_ch.valid <= 1'b0;
					stimulus_done  <= 1'b1;
				end
			end
		end
	end

	// Predict at the accepting edge and note the handshake for the driver.
	always @(posedge clk) begin
		pixel_taken = arst_n && pixel_ch.valid && pixel_ch.ready;
		if (pixel_taken) begin
			pixel_t p;
			p.red = pixel_ch.red;
			p.green = pixel_ch.green;
			p.blue = pixel_ch.blue;
			expected_colors.push_back(convert_pixel(p));
		end
	end

	// Long receiver hold-off once, early on, so the pipe fills and stalls input.
	initial begin
		hold_off = 1'b0;
		wait (arst_n);
		repeat (60) @(posedge clk);
		hold_off = 1'b1;
		repeat (80) @(posedge clk);
		hold_off = 1'b0;
	end

	// Receiver back-pressure.
	initial result_ch.ready = 1'b0;
	int sink_gap;
	always @(negedge clk) begin
		if (!arst_n || hold_off) begin
			result_ch.ready <= 1'b0;
		end else if (sink_gap > 0) begin
			sink_gap--;
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= 1'b1;
			if ($urandom_range(3) == 0) sink_gap = gap_len();
		end
	end

	// Monitor: check each taken word against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready) begin
			color_t want;
			if (expected_colors.size() == 0) begin
				$display("[%0t] unexpected result word", $time);
				mismatches++;
			end else begin
				want = expected_colors.pop_front();
				if (result_ch.hue !== want.hue)
					report_mismatch("hue", result_ch.hue, want.hue);
				if (result_ch.hsv_saturation !== want.hsv_sat)
					report_mismatch("hsv_saturation", result_ch.hsv_saturation, want.hsv_sat);
				if (result_ch.hsv_value !== want.value)
					report_mismatch("hsv_value", result_ch.hsv_value, want.value);
				if (result_ch.hsl_saturation !== want.hsl_sat)
					report_mismatch("hsl_saturation", result_ch.hsl_saturation, want.hsl_sat);
				if (result_ch.lightness_doubled !== want.light2)
					report_mismatch("lightness_doubled", result_ch.lightness_doubled,
						want.light2);
			end
			colors_seen++;
		end
	end

	// End of run: drain, then wait out the pipeline latency.
	initial begin
		mismatches = 0;
		pixels_sent = 0;
		colors_seen = 0;
		stimulus_done = 1'b0;
		drive_gap = 0;
		sink_gap = 0;
		wait (stimulus_done);
		wait (expected_colors.size() == 0);
		repeat (40) @(posedge clk);
		if (expected_colors.size() != 0) begin
			$display("[%0t] %0d result words never arrived", $time, expected_colors.size());
			mismatches++;
		end
		$display("Converted %0d pixels, checked %0d result words", pixels_sent, colors_seen);
		$display("Covered greys, primaries, hue ties, red wrap and input stall");
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	initial begin
		#2ms;
		$display("Timeout waiting for results");
		$display("Mismatches found");
		$finish;
	end

endmodule

[rgb_to_hsv_hsl_convert.f]
sv/rhc_pkg.sv
sv/rhc_if.sv
sv/rgb_to_hsv_hsl_convert.sv
verif/tb.sv
